### rtl/schema_text_lexer_defines.svh
// Assertion macros shared by the schema text lexer RTL.
`ifndef SCHEMA_TEXT_LEXER_DEFINES_SVH
`define SCHEMA_TEXT_LEXER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define STL_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stl: assertion failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define STL_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stl: assertion failed");
`else
`define STL_ASSERT_IMP(label, ante, cons)
`define STL_ASSERT_NXT(label, ante, cons)
`endif

`endif

### rtl/stl_pkg.sv
// Types and character constants for the schema text lexer.
`timescale 1ns / 1ps

package stl_pkg;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_BSTAR  = 3'd4,
    MODE_ERROR  = 3'd5
  } scan_mode_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_IDENT = 2'd1,
    KIND_INT   = 2'd2
  } token_kind_t;

  typedef enum logic [2:0] {
    CLS_IDENT = 3'd0,
    CLS_INT   = 3'd1,
    CLS_SYM   = 3'd2,
    CLS_END   = 3'd3,
    CLS_ERR   = 3'd4
  } token_class_t;

  typedef enum logic [1:0] {
    CAUSE_NONE  = 2'd0,
    CAUSE_SLASH = 2'd1,
    CAUSE_OPEN  = 2'd2
  } error_cause_t;

  localparam logic [15:0] LINE_MAX = 16'hFFFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_US    = 8'h5F;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  // Scanner state carried from byte to byte.
  typedef struct packed {
    scan_mode_t  mode;
    token_kind_t kind;
    logic [15:0] line;
  } scan_state_t;

  // One result beat.
  typedef struct packed {
    token_class_t token_class;
    logic         token_start;
    logic [7:0]   byte_out;
    logic [15:0]  line_number;
    error_cause_t error_cause;
  } out_beat_t;

  localparam scan_state_t SCAN_RESET = '{mode: MODE_NORMAL, kind: KIND_NONE, line: 16'd0};

endpackage

### rtl/stl_if.sv
// Valid/ready channel interfaces for the lexer input and result streams.
`timescale 1ns / 1ps

interface stl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface stl_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_class;
  logic        token_start;
  logic [7:0]  byte_out;
  logic [15:0] line_number;
  logic [1:0]  error_cause;

  modport source (output valid, output token_class, output token_start,
                  output byte_out, output line_number, output error_cause,
                  input ready);
  modport sink   (input valid, input token_class, input token_start,
                  input byte_out, input line_number, input error_cause,
                  output ready);
endinterface

### rtl/stl_scan.sv
// Combinational scan step: one byte plus current state gives next state and result.
`timescale 1ns / 1ps

module stl_scan
  import stl_pkg::*;
(
  input  logic [7:0]  byte_i,
  input  scan_state_t cur_i,
  output scan_state_t nxt_o,
  output logic        res_valid_o,
  output out_beat_t   res_o
);

  logic        is_alpha;
  logic        is_digit;
  logic        is_blank;
  logic [15:0] line_inc;

  assign is_alpha = (byte_i >= CH_LO_A && byte_i <= CH_LO_Z) ||
                    (byte_i >= CH_UP_A && byte_i <= CH_UP_Z) || (byte_i == CH_US);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB) || (byte_i == CH_CR) ||
                    (byte_i == CH_VT) || (byte_i == CH_FF);
  // saturating newline count
  assign line_inc = (cur_i.line == LINE_MAX) ? cur_i.line : cur_i.line + 16'd1;

  always_comb begin
    nxt_o                = cur_i;
    res_valid_o          = 1'b0;
    res_o.token_class    = CLS_END;
    res_o.token_start    = 1'b0;
    res_o.byte_out       = CH_NUL;
    res_o.line_number    = cur_i.line;
    res_o.error_cause    = CAUSE_NONE;

    if (byte_i == CH_NUL) begin
      nxt_o = SCAN_RESET;
      if (cur_i.mode == MODE_SLASH) begin
        res_valid_o       = 1'b1;
        res_o.token_class = CLS_ERR;
        res_o.error_cause = CAUSE_SLASH;
      end else if (cur_i.mode == MODE_BLOCK || cur_i.mode == MODE_BSTAR) begin
        res_valid_o       = 1'b1;
        res_o.token_class = CLS_ERR;
        res_o.error_cause = CAUSE_OPEN;
      end else if (cur_i.mode != MODE_ERROR) begin
        res_valid_o       = 1'b1;
      end
    end else begin
      unique case (cur_i.mode)
        MODE_SLASH: begin
          if (byte_i == CH_SLASH) begin
            nxt_o.mode = MODE_LINE;
          end else if (byte_i == CH_STAR) begin
            nxt_o.mode = MODE_BLOCK;
          end else begin
            nxt_o.mode        = MODE_ERROR;
            res_valid_o       = 1'b1;
            res_o.token_class = CLS_ERR;
            res_o.error_cause = CAUSE_SLASH;
          end
        end
        MODE_LINE: begin
          if (byte_i == CH_NL) begin
            nxt_o.line = line_inc;
            nxt_o.mode = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (byte_i == CH_NL) begin
            nxt_o.line = line_inc;
          end else if (byte_i == CH_STAR) begin
            nxt_o.mode = MODE_BSTAR;
          end
        end
        MODE_BSTAR: begin
          if (byte_i == CH_SLASH) begin
            nxt_o.mode = MODE_NORMAL;
          end else if (byte_i != CH_STAR) begin
            if (byte_i == CH_NL) begin
              nxt_o.line = line_inc;
            end
            nxt_o.mode = MODE_BLOCK;
          end
        end
        MODE_NORMAL: begin
          if (is_blank) begin
            nxt_o.kind = KIND_NONE;
          end else if (byte_i == CH_NL) begin
            nxt_o.kind = KIND_NONE;
            nxt_o.line = line_inc;
          end else if (byte_i == CH_SLASH) begin
            nxt_o.kind = KIND_NONE;
            nxt_o.mode = MODE_SLASH;
          end else if (is_alpha) begin
            nxt_o.kind        = KIND_IDENT;
            res_valid_o       = 1'b1;
            res_o.token_class = CLS_IDENT;
            res_o.token_start = (cur_i.kind != KIND_IDENT);
            res_o.byte_out    = byte_i;
          end else if (is_digit) begin
            res_valid_o    = 1'b1;
            res_o.byte_out = byte_i;
            if (cur_i.kind == KIND_IDENT) begin
              res_o.token_class = CLS_IDENT;
            end else if (cur_i.kind == KIND_INT) begin
              res_o.token_class = CLS_INT;
            end else begin
              nxt_o.kind        = KIND_INT;
              res_o.token_class = CLS_INT;
              res_o.token_start = 1'b1;
            end
          end else begin
            nxt_o.kind        = KIND_NONE;
            res_valid_o       = 1'b1;
            res_o.token_class = CLS_SYM;
            res_o.token_start = 1'b1;
            res_o.byte_out    = byte_i;
          end
        end
        default: begin
          // error mode and spare codes: drop bytes until end of text
        end
      endcase
    end
  end

endmodule

### rtl/schema_text_lexer.sv
// Top level of the streaming schema text lexer.
`timescale 1ns / 1ps

// schema_text_lexer takes one text byte per beat on in_ch and returns at most
// one result beat per byte on out_ch. Blanks, newlines, line comments and
// block comments give no result; newlines (also inside block comments) bump
// a line counter that saturates at 65535. Token bytes come out with their
// class (identifier, integer, symbol), a token-start flag and the line
// number. Byte 0 ends the text: it yields an end beat (or an error beat for
// a dangling slash or an open block comment) and returns the lexer to its
// reset state. After a lone-slash error, bytes are dropped until byte 0, which gives no beat.
// Throughput is one byte per clock when no stall holds the input side. A taken
// byte sits in the input register, is scanned there, and its result is loaded
// into the result register when the byte retires, and is offered from there.
// The input side keeps flowing while one result waits in the output
// register; it stalls only when the input register also holds a byte that
// produces a result. Bytes that produce no result never wait on out_ready.

`include "schema_text_lexer_defines.svh"

module schema_text_lexer
  import stl_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  stl_in_if.sink   in_ch,
  stl_out_if.source out_ch
);

  // input stage
  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_byte_r;
  logic        s1_fire;

  // scanner state
  scan_state_t st_r, st_nxt;
  scan_state_t scan_nxt;
  logic        res_valid;
  out_beat_t   res;

  // result register
  logic        out_valid_r, out_valid_nxt;
  out_beat_t   out_beat_r;
  logic        out_load;

  stl_scan u_scan (
    .byte_i      (s1_byte_r),
    .cur_i       (st_r),
    .nxt_o       (scan_nxt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // The held byte retires when it has no result, or the result slot is
  // empty or being emptied this cycle.
  assign s1_fire  = s1_valid_r && (!res_valid || !out_valid_r || out_ch.ready);
  assign out_load = s1_fire && res_valid;
  assign in_ch.ready = !s1_valid_r || s1_fire;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.valid && in_ch.ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    st_nxt = s1_fire ? scan_nxt : st_r;

    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= SCAN_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.byte_in;
    end
    if (out_load) begin
      out_beat_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.token_class = out_beat_r.token_class;
  assign out_ch.token_start = out_beat_r.token_start;
  assign out_ch.byte_out    = out_beat_r.byte_out;
  assign out_ch.line_number = out_beat_r.line_number;
  assign out_ch.error_cause = out_beat_r.error_cause;

  // error beats carry a cause and no token data
  `STL_ASSERT_IMP(a_err_beat_clean,
                  out_valid_r && out_beat_r.token_class == CLS_ERR,
                  !out_beat_r.token_start && out_beat_r.byte_out == CH_NUL &&
                  out_beat_r.error_cause != CAUSE_NONE)
  // error mode swallows every non-end byte
  `STL_ASSERT_IMP(a_err_mode_silent, s1_fire && st_r.mode == MODE_ERROR, !res_valid)
  // the line count only moves forward until end of text
  `STL_ASSERT_NXT(a_line_monotonic, s1_fire && s1_byte_r != CH_NUL,
                  st_r.line >= $past(st_r.line))
  // a byte held in the input stage waits unchanged
  `STL_ASSERT_NXT(a_s1_hold, s1_valid_r && !s1_fire, s1_valid_r && $stable(s1_byte_r))

endmodule

### dv/tb.sv
// Self-checking testbench for the streaming schema text lexer.
`timescale 1ns / 1ps

module tb;
  import stl_pkg::*;

  localparam int CYCLE_LIMIT  = 60000;   // generous ceiling, long hold included
  localparam int PHASE_BYTES  = 650;     // random bytes per phase
  localparam int HOLD_CYCLES  = 300;     // long receiver stall, fills the block
  localparam int DRAIN_CYCLES = 8;       // result path is two registers deep

  localparam out_beat_t NO_BEAT = '0;

  // One row of the directed table: a byte, and optionally a hand-typed result.
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    out_beat_t  want;
  } dir_row_t;

  localparam int DIR_ROWS = 30;

  // Rows with typed = 1 carry the result written out by hand; the others are
  // left to the lexer model below.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // identifier right after reset
    {"a",      1'b1, CLS_IDENT, 1'b1, "a", 16'd0, CAUSE_NONE},
    // digit continues an identifier
    {"9",      1'b0, NO_BEAT},
    // top byte value is a symbol
    {8'hFF,    1'b1, CLS_SYM, 1'b1, 8'hFF, 16'd0, CAUSE_NONE},
    // integer, then a letter right after digits opens a new identifier
    {"1",      1'b0, NO_BEAT},
    {"x",      1'b0, NO_BEAT},
    {CH_NL,    1'b0, NO_BEAT},
    // line comment closed by newline
    {CH_SLASH, 1'b0, NO_BEAT},
    {CH_SLASH, 1'b0, NO_BEAT},
    {CH_NL,    1'b0, NO_BEAT},
    // slash-star-slash: the opening star must not close the comment
    {CH_SLASH, 1'b0, NO_BEAT},
    {CH_STAR,  1'b0, NO_BEAT},
    {CH_SLASH, 1'b0, NO_BEAT},
    // newline inside a block comment still counts
    {CH_NL,    1'b0, NO_BEAT},
    // run of stars before the closing slash
    {CH_STAR,  1'b0, NO_BEAT},
    {CH_STAR,  1'b0, NO_BEAT},
    {CH_SLASH, 1'b0, NO_BEAT},
    // lowest nonzero byte is a symbol
    {8'h01,    1'b0, NO_BEAT},
    // end of text on line 3
    {CH_NUL,   1'b1, CLS_END, 1'b0, 8'h00, 16'd3, CAUSE_NONE},
    // lone slash, following byte consumed, then error mode ignores input
    {CH_SLASH, 1'b0, NO_BEAT},
    {"x",      1'b1, CLS_ERR, 1'b0, 8'h00, 16'd0, CAUSE_SLASH},
    {"q",      1'b0, NO_BEAT},
    {CH_NUL,   1'b0, NO_BEAT},
    // slash directly before end of text
    {CH_SLASH, 1'b0, NO_BEAT},
    {CH_NUL,   1'b1, CLS_ERR, 1'b0, 8'h00, 16'd0, CAUSE_SLASH},
    // block comment still open at end of text
    {CH_SLASH, 1'b0, NO_BEAT},
    {CH_STAR,  1'b0, NO_BEAT},
    {CH_NUL,   1'b1, CLS_ERR, 1'b0, 8'h00, 16'd0, CAUSE_OPEN},
    // line comment open at end of text ends normally
    {CH_SLASH, 1'b0, NO_BEAT},
    {CH_SLASH, 1'b0, NO_BEAT},
    {CH_NUL,   1'b1, CLS_END, 1'b0, 8'h00, 16'd0, CAUSE_NONE}
  };

  logic clk;
  logic rst_n;

  stl_in_if  in_ch ();
  stl_out_if out_ch ();

  schema_text_lexer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Lexer model state, mirrors the block's scanner registers.
  scan_mode_t  lex_mode = MODE_NORMAL;
  token_kind_t lex_kind = KIND_NONE;
  logic [15:0] lex_line = '0;

  // Results still owed by the block, oldest first.
  out_beat_t tokens_due [$];

  int  error_count  = 0;
  int  bytes_sent   = 0;
  int  cycle_count  = 0;
  int  src_idle_pct = 0;
  int  sink_idle_pct = 0;
  int  hold_left    = 0;
  logic hold_go     = 1'b0;
  logic hold_taken  = 1'b0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer model: one byte in, at most one result out. Updates lex_* in place.
  // ---------------------------------------------------------------------------
  function automatic bit lex_predict(input logic [7:0] b, output out_beat_t r);
    bit hit;
    bit nl_seen;
    hit     = 1'b0;
    nl_seen = 1'b0;
    r = NO_BEAT;
    // No result ever coincides with a line bump, so the current count is it.
    r.line_number = lex_line;
    if (b == CH_NUL) begin
      // End of text: error mode swallows it, dangling slash / open comment
      // turn it into an error, anything else gives a plain end beat.
      hit = (lex_mode != MODE_ERROR);
      if (lex_mode == MODE_SLASH) begin
        r.token_class = CLS_ERR;
        r.error_cause = CAUSE_SLASH;
      end else if (lex_mode == MODE_BLOCK || lex_mode == MODE_BSTAR) begin
        r.token_class = CLS_ERR;
        r.error_cause = CAUSE_OPEN;
      end else begin
        r.token_class = CLS_END;
      end
      lex_mode = MODE_NORMAL;
      lex_kind = KIND_NONE;
      lex_line = '0;
    end else begin
      case (lex_mode)
        MODE_SLASH: begin
          if (b == CH_SLASH) lex_mode = MODE_LINE;
          else if (b == CH_STAR) lex_mode = MODE_BLOCK;
          else begin
            // lone slash: this byte is eaten, error beat goes out
            lex_mode = MODE_ERROR;
            hit = 1'b1;
            r.token_class = CLS_ERR;
            r.error_cause = CAUSE_SLASH;
          end
        end
        MODE_LINE: begin
          if (b == CH_NL) begin
            nl_seen  = 1'b1;
            lex_mode = MODE_NORMAL;
          end
        end
        MODE_BLOCK: begin
          if (b == CH_NL) nl_seen = 1'b1;
          else if (b == CH_STAR) lex_mode = MODE_BSTAR;
        end
        MODE_BSTAR: begin
          // a slash after any run of stars closes; more stars keep waiting
          if (b == CH_SLASH) lex_mode = MODE_NORMAL;
          else if (b != CH_STAR) begin
            nl_seen  = (b == CH_NL);
            lex_mode = MODE_BLOCK;
          end
        end
        MODE_NORMAL: begin
          if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_VT || b == CH_FF) begin
            lex_kind = KIND_NONE;
          end else if (b == CH_NL) begin
            lex_kind = KIND_NONE;
            nl_seen  = 1'b1;
          end else if (b == CH_SLASH) begin
            lex_kind = KIND_NONE;
            lex_mode = MODE_SLASH;
          end else if ((b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
                       b == CH_US) begin
            hit = 1'b1;
            r.token_class = CLS_IDENT;
            r.token_start = (lex_kind != KIND_IDENT);
            r.byte_out    = b;
            lex_kind = KIND_IDENT;
          end else if (b >= CH_ZERO && b <= CH_NINE) begin
            hit = 1'b1;
            r.byte_out = b;
            if (lex_kind == KIND_IDENT) begin
              r.token_class = CLS_IDENT;
            end else begin
              r.token_class = CLS_INT;
              r.token_start = (lex_kind == KIND_NONE);
              lex_kind = KIND_INT;
            end
          end else begin
            // everything else, high bytes included, is a one-byte symbol
            hit = 1'b1;
            r.token_class = CLS_SYM;
            r.token_start = 1'b1;
            r.byte_out    = b;
            lex_kind = KIND_NONE;
          end
        end
        default: ;  // error mode: drop until byte 0
      endcase
      if (nl_seen && lex_line != LINE_MAX) lex_line = lex_line + 16'd1;
    end
    return hit;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gaps, then hold valid until the beat is taken. The model
  // runs at the accepting edge, so expectations are queued long before the
  // result can show up.
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input bit typed = 1'b0,
                            input out_beat_t want = '0);
    out_beat_t r;
    bit        hit;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.byte_in <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    hit = lex_predict(b, r);
    // hand-typed rows override the model's result, the model still tracks state
    if (typed) tokens_due = {tokens_due, want};
    else if (hit) tokens_due = {tokens_due, r};
    bytes_sent++;
  endtask

  function automatic logic [7:0] rand_letter();
    case ($urandom_range(2))
      0:       return 8'($urandom_range(CH_LO_Z, CH_LO_A));
      1:       return 8'($urandom_range(CH_UP_Z, CH_UP_A));
      default: return CH_US;
    endcase
  endfunction

  // One text: a handful of well-formed pieces, now and then a broken tail,
  // always closed by byte 0.
  task automatic send_random_text();
    int pieces;
    int len;
    int p;
    int k;
    logic [7:0] c;
    logic [7:0] prev;
    pieces = $urandom_range(12, 2);
    for (p = 0; p < pieces; p++) begin
      case ($urandom_range(9))
        0, 1: begin  // identifier
          offer_byte(rand_letter());
          len = $urandom_range(6);
          for (k = 0; k < len; k++)
            offer_byte(($urandom_range(3) == 0) ? 8'($urandom_range(CH_NINE, CH_ZERO))
                                                : rand_letter());
        end
        2: begin  // integer, sometimes glued to a following identifier
          len = $urandom_range(5, 1);
          for (k = 0; k < len; k++) offer_byte(8'($urandom_range(CH_NINE, CH_ZERO)));
          if ($urandom_range(3) == 0) offer_byte(rand_letter());
        end
        3: begin  // symbol, any byte but a slash
          c = 8'($urandom_range(255, 1));
          if (c == CH_SLASH) c = "+";
          offer_byte(c);
        end
        4: begin  // blank
          case ($urandom_range(4))
            0:       offer_byte(CH_SPACE);
            1:       offer_byte(CH_TAB);
            2:       offer_byte(CH_CR);
            3:       offer_byte(CH_VT);
            default: offer_byte(CH_FF);
          endcase
        end
        5: offer_byte(CH_NL);
        6: begin  // line comment
          offer_byte(CH_SLASH);
          offer_byte(CH_SLASH);
          len = $urandom_range(6);
          for (k = 0; k < len; k++) begin
            c = 8'($urandom_range(255, 1));
            if (c == CH_NL) c = "z";
            offer_byte(c);
          end
          offer_byte(CH_NL);
        end
        7: begin  // block comment, star run before the close
          offer_byte(CH_SLASH);
          offer_byte(CH_STAR);
          prev = CH_NUL;
          len = $urandom_range(8);
          for (k = 0; k < len; k++) begin
            case ($urandom_range(3))
              0:       c = CH_NL;
              1:       c = CH_STAR;
              default: c = 8'($urandom_range(255, 1));
            endcase
            if (c == CH_SLASH && prev == CH_STAR) c = CH_NL;
            offer_byte(c);
            prev = c;
          end
          len = $urandom_range(3, 1);
          for (k = 0; k < len; k++) offer_byte(CH_STAR);
          offer_byte(CH_SLASH);
        end
        default: begin  // mixed token bytes back to back
          len = $urandom_range(4, 1);
          for (k = 0; k < len; k++) offer_byte(8'($urandom_range(CH_LO_Z, CH_ZERO)));
        end
      endcase
    end
    // broken tails: lone slash + junk, slash at end, comment left open
    case ($urandom_range(19))
      0: begin
        offer_byte(CH_SLASH);
        c = 8'($urandom_range(255, 1));
        if (c == CH_SLASH || c == CH_STAR) c = "k";
        offer_byte(c);
        len = $urandom_range(4);
        for (k = 0; k < len; k++) offer_byte(8'($urandom_range(255, 1)));
      end
      1: offer_byte(CH_SLASH);
      2: begin
        offer_byte(CH_SLASH);
        offer_byte(CH_STAR);
        len = $urandom_range(3);
        for (k = 0; k < len; k++) offer_byte(8'($urandom_range(CH_STAR, CH_SPACE)));
      end
      default: ;
    endcase
    offer_byte(CH_NUL);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold-off, and the scoreboard.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_beat_t want;
    if (hold_go && !hold_taken) begin
      hold_taken   <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (tokens_due.size() == 0) begin
        $error("unexpected result beat: class %0d byte %0h", out_ch.token_class,
               out_ch.byte_out);
        error_count++;
      end else begin
        want = tokens_due.pop_front();
        if (out_ch.token_class !== want.token_class) begin
          $error("token_class: expected %0d, got %0d", want.token_class, out_ch.token_class);
          error_count++;
        end
        if (out_ch.token_start !== want.token_start) begin
          $error("token_start: expected %0d, got %0d", want.token_start, out_ch.token_start);
          error_count++;
        end
        if (out_ch.byte_out !== want.byte_out) begin
          $error("byte_out: expected %0h, got %0h", want.byte_out, out_ch.byte_out);
          error_count++;
        end
        if (out_ch.line_number !== want.line_number) begin
          $error("line_number: expected %0d, got %0d", want.line_number, out_ch.line_number);
          error_count++;
        end
        if (out_ch.error_cause !== want.error_cause) begin
          $error("error_cause: expected %0d, got %0d", want.error_cause, out_ch.error_cause);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.byte_in = '0;
    out_ch.ready  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 1: light sender gaps, heavy receiver stalls, plus the long hold.
    src_idle_pct  = 16;
    sink_idle_pct = 46;
    for (i = 0; i < DIR_ROWS; i++)
      offer_byte(DIR_TABLE[i].b, DIR_TABLE[i].typed, DIR_TABLE[i].want);

    // Receiver goes quiet while the sender keeps pushing token bytes.
    hold_go <= 1'b1;
    while (bytes_sent < DIR_ROWS + PHASE_BYTES) send_random_text();

    // Sender pauses until every owed result is out.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tokens_due.size() != 0) @(posedge clk);

    // Phase 2: roles swapped.
    src_idle_pct  = 46;
    sink_idle_pct = 16;
    while (bytes_sent < DIR_ROWS + 2 * PHASE_BYTES) send_random_text();

    // Phase 3: full rate both sides.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    while (bytes_sent < DIR_ROWS + 3 * PHASE_BYTES) send_random_text();
    in_ch.valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule
